/* rtl/core/fvst_pkg.sv */
`default_nettype none

package fvst_pkg;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b0_0000_0001,
    ST_CLAMP = 9'b0_0000_0010,
    ST_MUL   = 9'b0_0000_0100,
    ST_DIV   = 9'b0_0000_1000,
    ST_SNAP  = 9'b0_0001_0000,
    ST_ACC   = 9'b0_0010_0000,
    ST_EMIT  = 9'b0_0100_0000,
    ST_FPS   = 9'b0_1000_0000,
    ST_MOD   = 9'b1_0000_0000
  } state_e;

  typedef enum logic [1:0] {
    CFG_FIXED_STEP   = 2'd0,
    CFG_TARGET_TICKS = 2'd1,
    CFG_MAX_DELTA    = 2'd2,
    CFG_COUNTER_FREQ = 2'd3
  } cfg_idx_e;

  localparam int unsigned SNAP_DIVISOR = 4000;
  localparam int unsigned DIV_STEPS    = 64;
  localparam int unsigned RESULT_LIMIT = 16;

  localparam logic [31:0] RST_TARGET_TICKS = 32'd166666;
  localparam logic [31:0] RST_MAX_DELTA    = 32'd1000000;
  localparam logic [31:0] RST_COUNTER_FREQ = 32'd10000000;

endpackage

`default_nettype wire

/* rtl/core/fixed_variable_step_timer.sv */
// Frame timer for a fixed or variable timestep loop. Each input transfer is either a time sample
// of a free-running 64-bit counter or a reset command; a sample produces zero or more update
// transfers on the output, the final one of a sample marked by last_o. A reset command is handled
// without leaving idle. A sample passes through capture, clamp and scale of the delta, the shared
// one-bit-per-cycle divider that turns counter units into ticks, snapping and accumulation in
// fixed mode, the emission of each update plus, in fixed mode, a step to close the loop, and
// frame rate bookkeeping. When the per-second counter rolls over, the same divider runs
// again to reduce it modulo the counter frequency. Updates wait while the output is stalled, and
// a new item is taken as soon as the block is back in idle, even if the final update of the
// previous sample is still pending.
`default_nettype none

module fixed_variable_step_timer #(
  parameter int unsigned TICKS_PER_SECOND = 10000000,
  parameter int unsigned MAX_UPDATES      = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic [63:0] counter_now_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      elapsed_ticks_o,
  output logic [63:0]      total_ticks_o,
  output logic [31:0]      frame_count_o,
  output logic [31:0]      frames_per_second_o,
  output logic             last_o
);

  localparam int unsigned TPS_W  = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned PROD_W = 32 + TPS_W;
  localparam int unsigned CAP_HI = (MAX_UPDATES > fvst_pkg::RESULT_LIMIT) ?
                                   fvst_pkg::RESULT_LIMIT : MAX_UPDATES;
  localparam int unsigned CAP    = (CAP_HI < 1) ? 1 : CAP_HI;
  localparam int unsigned CNT_W  = $clog2(CAP + 1);
  localparam int unsigned DCNT_W = $clog2(fvst_pkg::DIV_STEPS);
  localparam logic [63:0] SNAP   = 64'(TICKS_PER_SECOND / fvst_pkg::SNAP_DIVISOR);
  localparam logic [TPS_W-1:0]  TPS_C = TPS_W'(TICKS_PER_SECOND);

  fvst_pkg::state_e state_q, state_d;

  logic        fixed_q;
  logic [31:0] target_q, max_delta_q, freq_q;

  logic [63:0] last_time_q, last_time_d;
  logic [63:0] sec_cnt_q, sec_cnt_d;
  logic [63:0] leftover_q, leftover_d;
  logic [63:0] elapsed_q, elapsed_d;
  logic [63:0] total_q, total_d;
  logic [31:0] frames_q, frames_d;
  logic [31:0] fis_q, fis_d;
  logic [31:0] fps_q, fps_d;
  logic [CNT_W-1:0] upd_cnt_q, upd_cnt_d;
  logic        out_valid_q, out_valid_d;

  logic [63:0] delta_q, delta_d;
  logic [31:0] fps_out_q, fps_out_d;
  logic        last_q, last_d;
  logic [63:0] div_dq_q, div_dq_d;
  logic [31:0] div_rem_q, div_rem_d;
  logic [DCNT_W-1:0] div_cnt_q, div_cnt_d;

  logic [32:0] div_shift, div_sub;
  logic        div_ge;
  logic [63:0] div_dq_step;
  logic [31:0] div_rem_step;
  logic        div_done;

  logic [PROD_W-1:0] prod;
  logic [63:0] diff;
  logic [64:0] acc_sum;
  logic [64:0] twice_target;
  logic        in_acc, out_free, can_step, is_final;
  logic [31:0] fis_inc;

  assign div_shift    = {div_rem_q, div_dq_q[63]};
  assign div_sub      = div_shift - {1'b0, freq_q};
  assign div_ge       = div_shift >= {1'b0, freq_q};
  assign div_rem_step = div_ge ? div_sub[31:0] : div_shift[31:0];
  assign div_dq_step  = {div_dq_q[62:0], div_ge};
  assign div_done     = div_cnt_q == DCNT_W'(fvst_pkg::DIV_STEPS - 1);

  assign prod         = PROD_W'(delta_q[31:0]) * PROD_W'(TPS_C);
  assign diff         = (delta_q > {32'b0, target_q}) ? (delta_q - {32'b0, target_q}) :
                                                        ({32'b0, target_q} - delta_q);
  assign acc_sum      = {1'b0, leftover_q} + {1'b0, delta_q};
  assign twice_target = {32'b0, target_q, 1'b0};

  assign in_stall_o   = state_q != fvst_pkg::ST_IDLE;
  assign in_acc       = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign can_step     = (upd_cnt_q != CNT_W'(CAP)) && (leftover_q >= {32'b0, target_q});
  assign is_final     = (upd_cnt_q == CNT_W'(CAP - 1)) ||
                        ({1'b0, leftover_q - {32'b0, target_q}} < twice_target - 65'(target_q));
  assign fis_inc      = fis_q + 32'(upd_cnt_q != '0);

  always_comb begin
    state_d     = state_q;
    last_time_d = last_time_q;
    sec_cnt_d   = sec_cnt_q;
    leftover_d  = leftover_q;
    elapsed_d   = elapsed_q;
    total_d     = total_q;
    frames_d    = frames_q;
    fis_d       = fis_q;
    fps_d       = fps_q;
    upd_cnt_d   = upd_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    delta_d     = delta_q;
    fps_out_d   = fps_out_q;
    last_d      = last_q;
    div_dq_d    = div_dq_q;
    div_rem_d   = div_rem_q;
    div_cnt_d   = div_cnt_q;
    unique case (state_q)
      fvst_pkg::ST_IDLE: begin
        if (in_acc) begin
          last_time_d = counter_now_i;
          if (command_i) begin
            leftover_d = '0;
            fps_d      = '0;
            fis_d      = '0;
            sec_cnt_d  = '0;
          end else begin
            delta_d = counter_now_i - last_time_q;
            state_d = fvst_pkg::ST_CLAMP;
          end
        end
      end
      fvst_pkg::ST_CLAMP: begin
        sec_cnt_d = sec_cnt_q + delta_q;
        if (delta_q > {32'b0, max_delta_q}) begin
          delta_d = {32'b0, max_delta_q};
        end
        state_d = fvst_pkg::ST_MUL;
      end
      fvst_pkg::ST_MUL: begin
        div_dq_d  = 64'(prod);
        div_rem_d = '0;
        div_cnt_d = '0;
        upd_cnt_d = '0;
        state_d   = fvst_pkg::ST_DIV;
      end
      fvst_pkg::ST_DIV: begin
        div_dq_d  = div_dq_step;
        div_rem_d = div_rem_step;
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_done) begin
          delta_d = div_dq_step;
          state_d = fixed_q ? fvst_pkg::ST_SNAP : fvst_pkg::ST_EMIT;
        end
      end
      fvst_pkg::ST_SNAP: begin
        if (diff < SNAP) begin
          delta_d = {32'b0, target_q};
        end
        state_d = fvst_pkg::ST_ACC;
      end
      fvst_pkg::ST_ACC: begin
        leftover_d = acc_sum[64] ? '1 : acc_sum[63:0];
        state_d    = fvst_pkg::ST_EMIT;
      end
      fvst_pkg::ST_EMIT: begin
        if (!fixed_q) begin
          if (out_free) begin
            elapsed_d   = delta_q;
            total_d     = total_q + delta_q;
            leftover_d  = '0;
            frames_d    = frames_q + 1'b1;
            fps_out_d   = fps_q;
            last_d      = 1'b1;
            out_valid_d = 1'b1;
            upd_cnt_d   = CNT_W'(1);
            state_d     = fvst_pkg::ST_FPS;
          end
        end else if (!can_step) begin
          state_d = fvst_pkg::ST_FPS;
        end else if (out_free) begin
          elapsed_d   = {32'b0, target_q};
          total_d     = total_q + {32'b0, target_q};
          leftover_d  = leftover_q - {32'b0, target_q};
          frames_d    = frames_q + 1'b1;
          fps_out_d   = fps_q;
          last_d      = is_final;
          out_valid_d = 1'b1;
          upd_cnt_d   = upd_cnt_q + 1'b1;
        end
      end
      fvst_pkg::ST_FPS: begin
        if (sec_cnt_q >= {32'b0, freq_q}) begin
          fps_d     = fis_inc;
          fis_d     = '0;
          div_dq_d  = sec_cnt_q;
          div_rem_d = '0;
          div_cnt_d = '0;
          state_d   = fvst_pkg::ST_MOD;
        end else begin
          fis_d   = fis_inc;
          state_d = fvst_pkg::ST_IDLE;
        end
      end
      fvst_pkg::ST_MOD: begin
        div_dq_d  = div_dq_step;
        div_rem_d = div_rem_step;
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_done) begin
          sec_cnt_d = {32'b0, div_rem_step};
          state_d   = fvst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fvst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fvst_pkg::ST_IDLE;
      fixed_q     <= 1'b0;
      target_q    <= fvst_pkg::RST_TARGET_TICKS;
      max_delta_q <= fvst_pkg::RST_MAX_DELTA;
      freq_q      <= fvst_pkg::RST_COUNTER_FREQ;
      last_time_q <= '0;
      sec_cnt_q   <= '0;
      leftover_q  <= '0;
      elapsed_q   <= '0;
      total_q     <= '0;
      frames_q    <= '0;
      fis_q       <= '0;
      fps_q       <= '0;
      upd_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_time_q <= last_time_d;
      sec_cnt_q   <= sec_cnt_d;
      leftover_q  <= leftover_d;
      elapsed_q   <= elapsed_d;
      total_q     <= total_d;
      frames_q    <= frames_d;
      fis_q       <= fis_d;
      fps_q       <= fps_d;
      upd_cnt_q   <= upd_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fvst_pkg::CFG_FIXED_STEP: begin
            fixed_q <= cfg_data_i[0];
          end
          fvst_pkg::CFG_TARGET_TICKS: begin
            if (cfg_data_i != '0) target_q <= cfg_data_i;
          end
          fvst_pkg::CFG_MAX_DELTA: begin
            max_delta_q <= cfg_data_i;
          end
          fvst_pkg::CFG_COUNTER_FREQ: begin
            if (cfg_data_i != '0) freq_q <= cfg_data_i;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q   <= delta_d;
    fps_out_q <= fps_out_d;
    last_q    <= last_d;
    div_dq_q  <= div_dq_d;
    div_rem_q <= div_rem_d;
    div_cnt_q <= div_cnt_d;
  end

  assign out_valid_o         = out_valid_q;
  assign elapsed_ticks_o     = elapsed_q;
  assign total_ticks_o       = total_q;
  assign frame_count_o       = frames_q;
  assign frames_per_second_o = fps_out_q;
  assign last_o              = last_q;

`ifndef SYNTHESIS
  a_load_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == fvst_pkg::ST_EMIT))
    else $error("Output became valid outside the update loop.");

  a_update_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_cnt_q <= CNT_W'(CAP))
    else $error("Update count exceeds the per-sample cap.");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (freq_q != '0) && (target_q != '0))
    else $error("Counter frequency or target ticks is zero.");

  a_frames_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (!out_stall_i || !$past(out_valid_q))) |->
    (frames_q == $past(frames_q) + 32'd1) || $stable(frames_q) || !$rose(out_valid_q))
    else $error("Frame count did not advance with a new update.");
`endif

endmodule

`default_nettype wire

/* bench/fixed_variable_step_timer_tb.sv */
`default_nettype none

module fixed_variable_step_timer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TICKS_PER_SECOND = 10000000;
  localparam int unsigned MAX_UPDATES      = 16;
  localparam int unsigned UPDATE_CAP       =
    (MAX_UPDATES > fvst_pkg::RESULT_LIMIT) ? fvst_pkg::RESULT_LIMIT :
    ((MAX_UPDATES < 1) ? 1 : MAX_UPDATES);
  localparam logic [63:0] TICKS            = 64'(TICKS_PER_SECOND);
  localparam logic [63:0] SNAP_TICKS       = TICKS / 64'(fvst_pkg::SNAP_DIVISOR);
  localparam logic        CMD_SAMPLE       = 1'b0;
  localparam logic        CMD_RESTART      = 1'b1;
  localparam int          SETTLE_CYCLES    = 200;
  localparam int          CYCLE_LIMIT      = 1500000;
  localparam int          HOLD_CYCLES      = 500;

  typedef struct {
    logic        command;
    logic [63:0] counter_now;
  } sample_t;

  typedef struct {
    logic [63:0] elapsed;
    logic [63:0] total;
    logic [31:0] frames;
    logic [31:0] fps;
    logic        last;
  } update_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = 2'd0;
  logic [31:0] cfg_data_i    = 32'd0;
  logic        in_valid_i    = 1'b0;
  logic        command_i     = 1'b0;
  logic [63:0] counter_now_i = 64'd0;
  logic        out_stall_i   = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [63:0] elapsed_ticks_o;
  logic [63:0] total_ticks_o;
  logic [31:0] frame_count_o;
  logic [31:0] frames_per_second_o;
  logic        last_o;

  fixed_variable_step_timer #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND),
    .MAX_UPDATES     (MAX_UPDATES)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .counter_now_i      (counter_now_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .elapsed_ticks_o    (elapsed_ticks_o),
    .total_ticks_o      (total_ticks_o),
    .frame_count_o      (frame_count_o),
    .frames_per_second_o(frames_per_second_o),
    .last_o             (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the timer registers and state.
  logic        mode_fixed  = 1'b0;
  logic [63:0] step_ticks  = 64'(fvst_pkg::RST_TARGET_TICKS);
  logic [63:0] delta_limit = 64'(fvst_pkg::RST_MAX_DELTA);
  logic [63:0] count_freq  = 64'(fvst_pkg::RST_COUNTER_FREQ);
  logic [63:0] prev_count      = 64'd0;
  logic [63:0] sec_accum       = 64'd0;
  logic [63:0] leftover        = 64'd0;
  logic [63:0] elapsed_last    = 64'd0;
  logic [63:0] total_acc       = 64'd0;
  logic [31:0] frame_total     = 32'd0;
  logic [31:0] frames_this_sec = 32'd0;
  logic [31:0] fps_latched     = 32'd0;

  sample_t     sample_queue[$];
  update_t     update_q[$];
  logic [63:0] stim_time = 64'd0;
  int          errors = 0;
  int          cycles = 0;
  int          results_seen = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          hold_left = 0;
  int          held_at = -1;
  int          seg_left = 0;
  int          stall_mode = 0;
  update_t     got_update;

  task automatic advance_timer(input sample_t s);
    logic [63:0] delta;
    logic [63:0] diff;
    logic [63:0] upd;
    update_t     u;
    if (s.command == CMD_RESTART) begin
      prev_count      = s.counter_now;
      leftover        = 64'd0;
      fps_latched     = 32'd0;
      frames_this_sec = 32'd0;
      sec_accum       = 64'd0;
    end else begin
      delta      = s.counter_now - prev_count;
      prev_count = s.counter_now;
      sec_accum  = sec_accum + delta;
      if (delta > delta_limit) delta = delta_limit;
      delta = (delta * TICKS) / count_freq;
      if (mode_fixed) begin
        diff = (delta > step_ticks) ? delta - step_ticks : step_ticks - delta;
        if (diff < SNAP_TICKS) delta = step_ticks;
        if (leftover > ~64'd0 - delta) leftover = ~64'd0;
        else leftover = leftover + delta;
        upd = leftover / step_ticks;
        if (upd > 64'(UPDATE_CAP)) upd = 64'(UPDATE_CAP);
      end else begin
        upd = 64'd1;
        leftover = 64'd0;
      end
      for (logic [63:0] k = 0; k < upd; k++) begin
        elapsed_last = mode_fixed ? step_ticks : delta;
        total_acc    = total_acc + elapsed_last;
        if (mode_fixed) leftover = leftover - step_ticks;
        frame_total  = frame_total + 32'd1;
        u.elapsed = elapsed_last;
        u.total   = total_acc;
        u.frames  = frame_total;
        u.fps     = fps_latched;
        u.last    = (k == upd - 1);
        update_q.push_back(u);
      end
      if (upd != 0) frames_this_sec = frames_this_sec + 32'd1;
      if (sec_accum >= count_freq) begin
        fps_latched     = frames_this_sec;
        frames_this_sec = 32'd0;
        sec_accum       = sec_accum % count_freq;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        advance_timer(sample_queue.pop_front());
      end
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        in_valid_i    <= 1'b1;
        command_i     <= sample_queue[0].command;
        counter_now_i <= sample_queue[0].counter_now;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // The receiver stalls in segments of its own and holds off for a long stretch twice.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (held_at != results_seen && (results_seen == 100 || results_seen == 300)) begin
      held_at = results_seen;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(1, 64);
        stall_mode = $urandom_range(0, 2);
      end else begin
        seg_left = seg_left - 1;
      end
      case (stall_mode)
        0: begin
          out_stall_i <= 1'b0;
        end
        1: begin
          out_stall_i <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_stall_i <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (update_q.size() == 0) begin
        $error("update transfer with no update expected");
        errors++;
      end else begin
        got_update = update_q.pop_front();
        check_field("elapsed_ticks", got_update.elapsed, elapsed_ticks_o);
        check_field("total_ticks", got_update.total, total_ticks_o);
        check_field("frame_count", 64'(got_update.frames), 64'(frame_count_o));
        check_field("frames_per_second", 64'(got_update.fps), 64'(frames_per_second_o));
        check_field("last", 64'(got_update.last), 64'(last_o));
      end
      results_seen <= results_seen + 1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("fixed_variable_step_timer_tb: errors");
      $finish;
    end
  end

  task automatic write_reg(input fvst_pkg::cfg_idx_e idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      fvst_pkg::CFG_FIXED_STEP: begin
        mode_fixed = data[0];
      end
      fvst_pkg::CFG_TARGET_TICKS: begin
        if (data != 0) step_ticks = 64'(data);
      end
      fvst_pkg::CFG_MAX_DELTA: begin
        delta_limit = 64'(data);
      end
      default: begin
        if (data != 0) count_freq = 64'(data);
      end
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_sample(input logic [63:0] delta);
    sample_t s;
    stim_time = stim_time + delta;
    s.command = CMD_SAMPLE;
    s.counter_now = stim_time;
    sample_queue.push_back(s);
  endtask

  task automatic add_restart(input logic [63:0] now);
    sample_t s;
    stim_time = now;
    s.command = CMD_RESTART;
    s.counter_now = now;
    sample_queue.push_back(s);
  endtask

  task automatic wait_idle();
    while (sample_queue.size() != 0 || in_valid_i || update_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_config();
    logic [31:0] v;
    write_reg(fvst_pkg::CFG_FIXED_STEP, $urandom);
    case ($urandom_range(0, 3))
      0: v = $urandom_range(1, 3000);
      1: v = 32'd166666;
      2: v = $urandom_range(1000, 2000000);
      default: v = $urandom;
    endcase
    write_reg(fvst_pkg::CFG_TARGET_TICKS, v);
    case ($urandom_range(0, 3))
      0: v = fvst_pkg::RST_MAX_DELTA;
      1: v = $urandom_range(0, 5000000);
      2: v = $urandom;
      default: v = 32'hFFFF_FFFF;
    endcase
    write_reg(fvst_pkg::CFG_MAX_DELTA, v);
    case ($urandom_range(0, 3))
      0: v = fvst_pkg::RST_COUNTER_FREQ;
      1: v = $urandom_range(1000, 100000000);
      2: v = $urandom;
      default: v = $urandom_range(1, 100);
    endcase
    write_reg(fvst_pkg::CFG_COUNTER_FREQ, v);
  endtask

  task automatic random_samples(input int count);
    logic [63:0] near;
    logic [63:0] jit;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        add_restart(($urandom_range(0, 1) == 0) ? stim_time : {$urandom, $urandom});
      end else if (pick < 10) begin
        add_sample({$urandom, $urandom});
      end else if (pick < 50) begin
        // Raw delta close to one target step, around the snapping window.
        near = (step_ticks * count_freq) / TICKS;
        jit  = count_freq / 64'(fvst_pkg::SNAP_DIVISOR) + 64'd2;
        near = near + 64'($urandom_range(0, 32'(2 * jit)));
        add_sample((near >= jit) ? near - jit : near);
      end else if (pick < 85) begin
        add_sample(64'($urandom_range(0, 3000000)));
      end else begin
        add_sample(64'($urandom));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Variable mode with reset values: zero delta, clamping, counter wrap, frame rate.
    add_sample(64'd0);
    add_sample(64'd10000);
    add_sample(64'd5000000);
    add_sample(64'd6000000);
    add_restart(64'hFFFF_FFFF_FFFF_FF00);
    add_sample(64'h200);
    add_sample(64'hFFFF_FFFF_FFFF_FEFF);
    wait_idle();

    // Fixed mode; zero writes to the target and the frequency must leave them alone.
    write_reg(fvst_pkg::CFG_FIXED_STEP, 32'h8000_0001);
    write_reg(fvst_pkg::CFG_TARGET_TICKS, 32'd0);
    write_reg(fvst_pkg::CFG_COUNTER_FREQ, 32'd0);
    add_sample(64'd166666);
    add_sample(64'd168000);
    add_sample(64'd170000);
    add_sample(64'd0);
    add_sample(64'd1000000);
    wait_idle();

    // Update cap, then a restart clears the surplus.
    write_reg(fvst_pkg::CFG_MAX_DELTA, 32'hFFFF_FFFF);
    write_reg(fvst_pkg::CFG_TARGET_TICKS, 32'd1);
    add_sample(64'h100_0000_0000);
    add_restart(stim_time);
    add_sample(64'd5);
    wait_idle();

    // Zero clamp in fixed mode snaps a small target.
    write_reg(fvst_pkg::CFG_TARGET_TICKS, 32'd100);
    write_reg(fvst_pkg::CFG_MAX_DELTA, 32'd0);
    write_reg(fvst_pkg::CFG_COUNTER_FREQ, 32'hFFFF_FFFF);
    add_sample(64'd12345);
    add_sample(64'd7);
    wait_idle();

    write_reg(fvst_pkg::CFG_FIXED_STEP, 32'hFFFF_FFFE);
    add_sample(64'd99);
    wait_idle();

    write_reg(fvst_pkg::CFG_FIXED_STEP, 32'd1);
    write_reg(fvst_pkg::CFG_TARGET_TICKS, 32'hFFFF_FFFF);
    write_reg(fvst_pkg::CFG_MAX_DELTA, 32'hFFFF_FFFF);
    write_reg(fvst_pkg::CFG_COUNTER_FREQ, 32'd1);
    add_sample(64'h2_0000_0000);
    add_restart({$urandom, $urandom});
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      random_config();
      random_samples(44);
      wait_idle();
    end

    // Smallest step at the highest rate keeps every sample at the update cap.
    write_reg(fvst_pkg::CFG_FIXED_STEP, 32'd1);
    write_reg(fvst_pkg::CFG_TARGET_TICKS, 32'd1);
    write_reg(fvst_pkg::CFG_MAX_DELTA, 32'hFFFF_FFFF);
    write_reg(fvst_pkg::CFG_COUNTER_FREQ, 32'd1);
    for (int i = 0; i < 20; i++) begin
      add_sample(64'h1_0000_0000 + 64'($urandom));
    end
    add_restart(stim_time);
    add_sample(64'd3);
    add_sample(64'd0);
    wait_idle();

    if (errors == 0) begin
      $display("fixed_variable_step_timer_tb: clean");
    end else begin
      $display("fixed_variable_step_timer_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
